// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the bitmap page transpose block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rstn, cond)
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== src/btlp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btlp_pkg
// Geometry constants and shared types of the bitmap page transpose block.
// ----------------------------------------------------------------------------
package btlp_pkg;

    localparam int HEADER_BYTES = 62;
    localparam int IMAGE_WIDTH  = 128;
    localparam int IMAGE_HEIGHT = 64;

    localparam int ROW_BYTES    = IMAGE_WIDTH / 8;
    localparam int FRAME_BYTES  = HEADER_BYTES + ROW_BYTES * IMAGE_HEIGHT;
    localparam int BAND_SLOTS   = 7;
    localparam int STORE_DEPTH  = BAND_SLOTS * ROW_BYTES;

    localparam int POS_W  = $clog2(FRAME_BYTES);
    localparam int COL_W  = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int Y_W    = $clog2(IMAGE_HEIGHT);
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int COLX_W = COL_W + 3;

    // where the next input byte lands in the frame
    typedef struct packed {
        logic             payload;
        logic             top;
        logic [2:0]       slot;
        logic [COL_W-1:0] col;
        logic [2:0]       page;
    } loc_t;

    // one gathered column byte group, row 0 on top
    typedef struct packed {
        logic [7:0][7:0]  rows;
        logic [2:0]       page;
        logic [COL_W-1:0] col;
    } burst_t;

    typedef enum logic [1:0] {
        G_IDLE,
        G_READ,
        G_LAST,
        G_HOLD
    } gstate_t;

endpackage

// ===== src/btlp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btlp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module btlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/btlp_locate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btlp_locate
// Frame position tracker: header skip, byte column and display row counters.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module btlp_locate
    import btlp_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic accept,
    output loc_t info
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [Y_W-1:0]   y_reg, y_next;
    logic             payload;

    assign payload = (pos_reg >= POS_W'(HEADER_BYTES));

    always_comb begin
        info.payload = payload;
        info.top     = payload && (y_reg[2:0] == 3'd0);
        info.slot    = y_reg[2:0] - 3'd1;
        info.col     = col_reg;
        info.page    = 3'(y_reg >> 3);
    end

    always_comb begin
        pos_next = pos_reg;
        col_next = col_reg;
        y_next   = y_reg;
        if (accept) begin
            if (pos_reg == POS_W'(FRAME_BYTES - 1)) begin
                pos_next = '0;
                col_next = '0;
                y_next   = Y_W'(IMAGE_HEIGHT - 1);
            end else begin
                pos_next = pos_reg + 1'b1;
                if (payload) begin
                    if (col_reg == COL_W'(ROW_BYTES - 1)) begin
                        col_next = '0;
                        y_next   = y_reg - 1'b1;
                    end else begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            col_reg <= '0;
            y_reg   <= Y_W'(IMAGE_HEIGHT - 1);
        end else begin
            pos_reg <= pos_next;
            col_reg <= col_next;
            y_reg   <= y_next;
        end
    end

    `ASSERT_IMPLIES(a_top_in_payload, aclk, aresetn, info.top, info.payload)

endmodule

// ===== src/btlp_gather.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btlp_gather
// Band store write path and seven-read gather sequencer for top-row bytes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module btlp_gather
    import btlp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_file_byte,
    input  loc_t       info,
    output logic       burst_valid,
    input  logic       burst_ready,
    output burst_t     burst
);

    gstate_t           state_reg, state_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [2:0]        page_reg, page_next;
    logic [7:0][7:0]   rows_reg, rows_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [2:0]        rd_slot_reg, rd_slot_next;

    logic              accept;
    logic              top_acc;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    assign accept  = s_valid && s_ready;
    assign top_acc = accept && info.top;
    assign wr_en   = accept && info.payload && !info.top;
    assign wr_addr = ADDR_W'(int'(info.slot) * ROW_BYTES + int'(info.col));

    btlp_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_band_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_file_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // outputs of the sequencer
    always_comb begin
        s_ready     = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = addr_reg;
        burst_valid = 1'b0;
        unique case (state_reg)
            G_IDLE: begin
                s_ready = 1'b1;
                rd_en   = top_acc;
                rd_addr = ADDR_W'(info.col);
            end
            G_READ: begin
                s_ready = !info.top && (!info.payload || info.col != col_reg);
                rd_en   = 1'b1;
            end
            G_LAST: begin
                s_ready = !info.top;
            end
            G_HOLD: begin
                s_ready     = !info.top;
                burst_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // next state of the sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            G_IDLE: begin
                if (top_acc) begin
                    state_next = G_READ;
                end
            end
            G_READ: begin
                if (cnt_reg == 3'(BAND_SLOTS - 1)) begin
                    state_next = G_LAST;
                end
            end
            G_LAST: begin
                state_next = G_HOLD;
            end
            G_HOLD: begin
                if (burst_ready) begin
                    state_next = G_IDLE;
                end
            end
            default: begin
                state_next = G_IDLE;
            end
        endcase
    end

    always_comb begin
        cnt_next     = cnt_reg;
        addr_next    = addr_reg;
        col_next     = col_reg;
        page_next    = page_reg;
        rows_next    = rows_reg;
        rd_pend_next = rd_en;
        rd_slot_next = rd_slot_reg;
        if (rd_pend_reg) begin
            rows_next[rd_slot_reg] = rd_data;
        end
        if (top_acc) begin
            rows_next[0] = s_file_byte;
            col_next     = info.col;
            page_next    = info.page;
            cnt_next     = 3'd1;
            rd_slot_next = 3'd1;
            addr_next    = ADDR_W'(int'(info.col) + ROW_BYTES);
        end else if (state_reg == G_READ) begin
            cnt_next     = cnt_reg + 3'd1;
            rd_slot_next = cnt_reg + 3'd1;
            addr_next    = ADDR_W'(int'(addr_reg) + ROW_BYTES);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= G_IDLE;
            cnt_reg     <= '0;
            rd_pend_reg <= 1'b0;
            rd_slot_reg <= '0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_pend_reg <= rd_pend_next;
            rd_slot_reg <= rd_slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        col_reg  <= col_next;
        page_reg <= page_next;
        rows_reg <= rows_next;
    end

    assign burst.rows = rows_reg;
    assign burst.page = page_reg;
    assign burst.col  = col_reg;

    `ASSERT_IMPLIES(a_top_only_idle, aclk, aresetn, top_acc, state_reg == G_IDLE)
    `ASSERT_NEXT(a_top_starts_read, aclk, aresetn, top_acc, state_reg == G_READ)
    `ASSERT_IMPLIES(a_no_clash, aclk, aresetn, wr_en && rd_en, wr_addr != rd_addr)

endmodule

// ===== src/btlp_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btlp_emit
// Result buffer: transposes a gathered group into eight column bytes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module btlp_emit
    import btlp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       burst_valid,
    output logic       burst_ready,
    input  burst_t     burst,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_lcd_byte,
    output logic [2:0] m_page,
    output logic [6:0] m_column,
    output logic       m_run_last
);

    logic              full_reg, full_next;
    logic [2:0]        k_reg, k_next;
    burst_t            buf_reg, buf_next;
    logic [COLX_W-1:0] colx;
    logic              m_accept;

    assign m_accept    = m_valid && m_ready;
    assign burst_ready = !full_reg || (m_ready && k_reg == 3'd7);

    always_comb begin
        full_next = full_reg;
        k_next    = k_reg;
        buf_next  = buf_reg;
        if (burst_valid && burst_ready) begin
            full_next = 1'b1;
            k_next    = 3'd0;
            buf_next  = burst;
        end else if (m_accept) begin
            if (k_reg == 3'd7) begin
                full_next = 1'b0;
            end else begin
                k_next = k_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
            k_reg    <= '0;
        end else begin
            full_reg <= full_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            m_lcd_byte[j] = ~buf_reg.rows[j][3'd7 - k_reg];
        end
    end

    assign colx       = {buf_reg.col, k_reg};
    assign m_valid    = full_reg;
    assign m_page     = buf_reg.page;
    assign m_column   = 7'(colx);
    assign m_run_last = (k_reg == 3'd7);

    `ASSERT_NEXT(a_burst_unbroken, aclk, aresetn, m_valid && !(m_ready && m_run_last), m_valid)

endmodule

// ===== src/bitmap_to_lcd_page_transpose.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_to_lcd_page_transpose
// Converts a bottom-up 1-bit bitmap file stream into vertical page bytes.
// ----------------------------------------------------------------------------
// Header bytes and bytes of the seven lower rows of each page are taken one
// per cycle unless held back as below; the latter are written to a 112-byte
// band memory. A byte of a page's top row starts a gather that reads the
// seven stored bytes of its column group, one memory read per cycle, and then
// hands the group to the result buffer, which sends eight column bytes, one
// per cycle while the receiver is ready. Top-row bytes are therefore taken
// only while no gather runs, and a run of them is paced by the result port; a
// lower-row byte whose column group is being gathered waits until its reads
// are done. The band memory needs no clearing after reset.
module bitmap_to_lcd_page_transpose
    import btlp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_file_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_lcd_byte,
    output logic [2:0] m_page,
    output logic [6:0] m_column,
    output logic       m_run_last
);

    loc_t   info;
    burst_t burst;
    logic   burst_valid;
    logic   burst_ready;

    btlp_locate u_locate (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_valid && s_ready),
        .info    (info)
    );

    btlp_gather u_gather (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_file_byte (s_file_byte),
        .info        (info),
        .burst_valid (burst_valid),
        .burst_ready (burst_ready),
        .burst       (burst)
    );

    btlp_emit u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .burst_valid (burst_valid),
        .burst_ready (burst_ready),
        .burst       (burst),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_lcd_byte  (m_lcd_byte),
        .m_page      (m_page),
        .m_column    (m_column),
        .m_run_last  (m_run_last)
    );

endmodule

// ===== verif/bitmap_to_lcd_page_transpose_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_to_lcd_page_transpose_test
// Streams the start of a bitmap frame through the transpose block: the
// header, the first page, and the first rows of the next page. A scoreboard
// class tracks the frame position and the band rows, builds the eight column
// bytes due for every top-row request, and checks each returned column byte
// in order. The sender works in random bursts and the receiver stalls on a
// pattern of its own. Once the receiver holds off long enough to back the
// block up, and once the sender drains the block.
// ----------------------------------------------------------------------------
module bitmap_to_lcd_page_transpose_test;
    import btlp_pkg::*;

    localparam int STREAM_BYTES = 210;
    localparam int DRAIN_AT     = HEADER_BYTES + 8 * ROW_BYTES - 6;
    localparam int HOLD_AFTER   = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 24;

    typedef struct packed {
        logic [7:0] lcd_byte;
        logic [2:0] page;
        logic [6:0] column;
        logic       run_last;
    } column_byte_t;

    class page_transpose_board;
        bit [POS_W-1:0] frame_pos;
        bit [7:0]       band_rows [STORE_DEPTH];
        column_byte_t   due_columns [$];
        int             fail_count;

        function new();
            frame_pos  = '0;
            fail_count = 0;
            foreach (band_rows[i]) band_rows[i] = '0;
        endfunction

        function int pending();
            return due_columns.size();
        endfunction

        task report(string what, int got, int want);
            $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $realtime, what, got, want);
            fail_count++;
        endtask

        // work out the column bytes an accepted request causes
        function void note_request(logic [7:0] file_byte);
            int           pos;
            int           off;
            int           row;
            int           group;
            int           y;
            int           page_row;
            int           col_index;
            logic [7:0]   rows [8];
            logic [7:0]   vertical;
            column_byte_t due;

            pos       = int'(frame_pos);
            frame_pos = (pos + 1 >= FRAME_BYTES) ? '0 : frame_pos + 1'b1;
            if (pos < HEADER_BYTES) return;
            off      = pos - HEADER_BYTES;
            row      = off / ROW_BYTES;
            group    = off % ROW_BYTES;
            y        = IMAGE_HEIGHT - 1 - row;
            page_row = y % 8;
            if (page_row != 0) begin
                band_rows[(page_row - 1) * ROW_BYTES + group] = file_byte;
                return;
            end
            rows[0] = file_byte;
            for (int j = 1; j < 8; j++) begin
                rows[j] = band_rows[(j - 1) * ROW_BYTES + group];
            end
            for (int k = 0; k < 8; k++) begin
                for (int j = 0; j < 8; j++) begin
                    vertical[j] = rows[j][7 - k];
                end
                col_index    = group * 8 + k;
                due.lcd_byte = ~vertical;
                due.page     = 3'(y / 8);
                due.column   = col_index[6:0];
                due.run_last = (k == 7);
                due_columns.push_back(due);
            end
        endfunction

        task check_result(logic [7:0] lcd_byte, logic [2:0] page, logic [6:0] column,
                          logic run_last);
            column_byte_t due;
            if (due_columns.size() == 0) begin
                report("unexpected column byte", lcd_byte, 0);
                return;
            end
            due = due_columns.pop_front();
            if (lcd_byte !== due.lcd_byte) report("lcd_byte", lcd_byte, due.lcd_byte);
            if (page !== due.page) report("page", page, due.page);
            if (column !== due.column) report("column", column, due.column);
            if (run_last !== due.run_last) report("run_last", run_last, due.run_last);
        endtask
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_file_byte;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_lcd_byte;
    logic [2:0] m_page;
    logic [6:0] m_column;
    logic       m_run_last;

    page_transpose_board board;

    bitmap_to_lcd_page_transpose dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_file_byte (s_file_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_lcd_byte  (m_lcd_byte),
        .m_page      (m_page),
        .m_column    (m_column),
        .m_run_last  (m_run_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("bitmap_to_lcd_page_transpose_test failed");
        $finish;
    end

    // extremes and a walking one in the first column groups of the first page
    function automatic logic [7:0] next_file_byte(int idx);
        int pos;
        int off;
        int row;
        int group;
        pos = idx % FRAME_BYTES;
        if (idx >= FRAME_BYTES || pos < HEADER_BYTES) return 8'($urandom_range(0, 255));
        off   = pos - HEADER_BYTES;
        row   = off / ROW_BYTES;
        group = off % ROW_BYTES;
        if (row >= 8 || group >= 3) return 8'($urandom_range(0, 255));
        case (group)
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'h80 >> row;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] file_byte);
        s_valid     <= 1'b1;
        s_file_byte <= file_byte;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_request(file_byte);
        @(negedge aclk);
    endtask

    initial begin
        int burst_left;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_file_byte = 8'h00;
        m_ready     = 1'b0;
        board       = new();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        burst_left = 0;
        for (int idx = 0; idx < STREAM_BYTES; idx++) begin
            if (burst_left == 0 || idx == DRAIN_AT) begin
                s_valid <= 1'b0;
                if (idx == DRAIN_AT) begin
                    while (board.pending() != 0) @(negedge aclk);
                end
                repeat ($urandom_range(1, 6)) @(negedge aclk);
                burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
            end
            burst_left--;
            send_byte(next_file_byte(idx));
        end
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (board.fail_count == 0) begin
            $display("bitmap_to_lcd_page_transpose_test passed");
        end else begin
            $display("bitmap_to_lcd_page_transpose_test failed");
        end
        $finish;
    end

    // receiver: rotates through three stall modes, with one long hold-off
    initial begin
        int  cycle_count;
        int  got_count;
        bit  held;
        int  mode;
        cycle_count = 0;
        got_count   = 0;
        held        = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (!held && got_count >= HOLD_AFTER) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            mode = (cycle_count / 97) % 3;
            case (mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge aclk);
            if (m_valid && m_ready) begin
                board.check_result(m_lcd_byte, m_page, m_column, m_run_last);
                got_count++;
            end
            cycle_count++;
        end
    end

endmodule
